### hw/rtl/u8u16_pkg.sv
// Shared types, constants and the lead byte classifier for the UTF-8 to
// UTF-16BE transcoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam logic [15:0] UNIT_BOM   = 16'hFEFF;
    localparam logic [15:0] UNIT_REPL  = 16'hFFFD;
    localparam logic [15:0] UNIT_HI    = 16'hD800;
    localparam logic [15:0] UNIT_LO    = 16'hDC00;
    localparam logic [20:0] PLANE_BASE = 21'h10000;
    localparam logic [20:0] BMP_MAX    = 21'h0FFFF;

    // One decode job: an optional byte order mark and up to four bytes that
    // are decoded as a self-contained string.
    typedef struct packed {
        logic            bom;
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_job;

    typedef struct packed {
        logic       valid;  // recognised lead pattern
        logic [2:0] len;    // sequence length, 1 for invalid leads
        logic [6:0] bits;   // payload bits of the lead
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] c);
        t_lead l;
        l.valid = 1'b1;
        l.len   = 3'd1;
        l.bits  = c[6:0];
        if (!c[7]) begin
            l.len = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            l.len  = 3'd2;
            l.bits = {2'b00, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            l.len  = 3'd3;
            l.bits = {3'b000, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            l.len  = 3'd4;
            l.bits = {4'b0000, c[2:0]};
        end else begin
            l.valid = 1'b0;
            l.len   = 3'd1;
            l.bits  = 7'd0;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/u8u16_front.sv
// Front end: accepts bytes, tracks the open sequence and issues decode jobs.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_valid,
    output                     logic o_ready,
    input  wire                logic [7:0] i_in_byte,
    input  wire                logic i_first_byte,
    input  wire                logic i_last_byte,
    input  wire                logic i_q_full,
    output                     logic o_push,
    output u8u16_pkg::t_job          o_job
);

    logic [2:0] r_need, n_need;
    logic [1:0] r_have, n_have;
    logic [7:0] r_held [3];

    logic       acc;
    logic [2:0] need_eff;
    logic [1:0] have_eff;
    logic [2:0] have_inc;
    u8u16_pkg::t_lead lead;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;
    assign lead    = u8u16_pkg::lead_decode(i_in_byte);

    // A first flag drops any open sequence.
    assign need_eff = i_first_byte ? 3'd0 : r_need;
    assign have_eff = i_first_byte ? 2'd0 : r_have;
    assign have_inc = {1'b0, have_eff} + 3'd1;

    always_comb begin
        n_need = need_eff;
        n_have = have_eff;
        o_push = 1'b0;
        o_job.bom = i_first_byte;
        o_job.len = 3'd0;
        for (int k = 0; k < 3; k++) begin
            o_job.bytes[k] = (2'(k) < have_eff) ? r_held[k] : i_in_byte;
        end
        o_job.bytes[3] = i_in_byte;

        if (i_last_byte) begin
            o_push    = acc;
            o_job.len = have_inc;
            n_need    = 3'd0;
            n_have    = 2'd0;
        end else if (need_eff == 3'd0) begin
            if (lead.len == 3'd1) begin
                o_push    = acc;
                o_job.len = 3'd1;
            end else begin
                o_push = acc && i_first_byte;
                n_need = lead.len;
                n_have = 2'd1;
            end
        end else if (have_inc >= need_eff) begin
            o_push    = acc;
            o_job.len = need_eff;
            n_need    = 3'd0;
            n_have    = 2'd0;
        end else begin
            n_have = have_inc[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= 3'd0;
            r_have <= 2'd0;
        end else if (acc) begin
            r_need <= n_need;
            r_have <= n_have;
        end
    end

    // Held bytes: only entries written in the open sequence are ever read.
    always_ff @(posedge i_clk) begin
        if (acc && !i_last_byte) begin
            for (int k = 0; k < 3; k++) begin
                if (have_eff == 2'(k)) begin
                    r_held[k] <= i_in_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/u8u16_queue.sv
// Small job queue between front end and decoder.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue #(
    parameter int unsigned DEPTH = u8u16_pkg::QueueDepth
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_push,
    input  wire u8u16_pkg::t_job     i_job,
    output                     logic o_full,
    output                     logic o_valid,
    output u8u16_pkg::t_job          o_job,
    input  wire                logic i_pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    u8u16_pkg::t_job r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/u8u16_back.sv
// Decoder back end: turns one job into UTF-16 units, one per cycle while
// the output is not stalled, through a registered output. Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_job_valid,
    input  wire u8u16_pkg::t_job     i_job,
    output                     logic o_pop,
    output                     logic o_valid,
    input  wire                logic i_ready,
    output                     logic [15:0] o_code_unit,
    output                     logic o_final_unit
);

    logic            r_busy;
    logic            r_bom;
    logic            r_lo_pend;
    logic [9:0]      r_lo;
    logic [2:0]      r_pos;
    logic [2:0]      r_len;
    logic [3:0][7:0] r_bytes;

    logic            r_out_valid;
    logic [15:0]     r_unit;
    logic            r_final;

    logic            can_load, emit, done, load;
    logic [1:0]      p0;
    logic [5:0]      b1, b2, b3;
    logic [2:0]      rem, step, pos_nx;
    logic [20:0]     cp, cp_m;
    logic [15:0]     unit;
    logic            fin;
    logic            n_bom, n_lo_pend;
    logic [9:0]      n_lo;
    logic [2:0]      n_pos;
    u8u16_pkg::t_lead lead;

    assign p0   = r_pos[1:0];
    assign lead = u8u16_pkg::lead_decode(r_bytes[p0]);
    assign b1   = r_bytes[2'(p0 + 2'd1)][5:0];
    assign b2   = r_bytes[2'(p0 + 2'd2)][5:0];
    assign b3   = r_bytes[2'(p0 + 2'd3)][5:0];
    assign rem  = r_len - r_pos;

    // Code point at the scan position; a bad lead or a lead that does not fit gives FFFD.
    always_comb begin
        if (!lead.valid || (lead.len > rem)) begin
            cp   = {5'd0, u8u16_pkg::UNIT_REPL};
            step = 3'd1;
        end else begin
            step = lead.len;
            case (lead.len)
                3'd2:    cp = {10'd0, lead.bits[4:0], b1};
                3'd3:    cp = {5'd0, lead.bits[3:0], b1, b2};
                3'd4:    cp = {lead.bits[2:0], b1, b2, b3};
                default: cp = {14'd0, lead.bits};
            endcase
        end
    end

    assign cp_m   = cp - u8u16_pkg::PLANE_BASE;
    assign pos_nx = r_pos + step;

    always_comb begin
        n_bom     = r_bom;
        n_lo_pend = r_lo_pend;
        n_lo      = r_lo;
        n_pos     = r_pos;
        priority if (r_bom) begin
            unit  = u8u16_pkg::UNIT_BOM;
            fin   = (r_len == 3'd0);
            n_bom = 1'b0;
        end else if (r_lo_pend) begin
            unit      = u8u16_pkg::UNIT_LO + {6'd0, r_lo};
            fin       = (r_pos == r_len);
            n_lo_pend = 1'b0;
        end else if (cp > u8u16_pkg::BMP_MAX) begin
            unit      = u8u16_pkg::UNIT_HI + {5'd0, cp_m[20:10]};
            fin       = 1'b0;
            n_lo_pend = 1'b1;
            n_lo      = cp_m[9:0];
            n_pos     = pos_nx;
        end else begin
            unit  = cp[15:0];
            fin   = (pos_nx == r_len);
            n_pos = pos_nx;
        end
    end

    assign can_load = !r_out_valid || i_ready;
    assign emit     = can_load && r_busy;
    assign done     = emit && fin;
    assign load     = (!r_busy || done) && i_job_valid;
    assign o_pop    = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_bom       <= 1'b0;
            r_lo_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy    <= 1'b1;
                r_bom     <= i_job.bom;
                r_lo_pend <= 1'b0;
            end else begin
                if (done) begin
                    r_busy <= 1'b0;
                end
                if (emit) begin
                    r_bom     <= n_bom;
                    r_lo_pend <= n_lo_pend;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pos   <= 3'd0;
            r_len   <= i_job.len;
            r_bytes <= i_job.bytes;
        end else if (emit) begin
            r_pos <= n_pos;
        end
        if (emit) begin
            r_lo    <= n_lo;
            r_unit  <= unit;
            r_final <= fin;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_unit  = r_unit;
    assign o_final_unit = r_final;

endmodule

`default_nettype wire

### hw/rtl/utf8_to_utf16be_transcoder.sv
// Top level of the UTF-8 to big-endian UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  -------------------------------
//  byte in   input      i_valid / o_ready   i_in_byte, i_first_byte,
//                                           i_last_byte
//  unit out  output     o_valid / i_ready   o_code_unit, o_final_unit
//
// Flow: the front end takes one byte per cycle whenever the job queue has
// room. The decoder emits one code unit per cycle while the output is not
// stalled; a byte giving none costs nothing there. A byte's first unit
// passes the job queue, decoder job registers and output register in turn.
// Reset is synchronous and clears sequence tracking, queue pointers and the
// output valid bit; there is no clearing pass. Held sequence bytes are not
// reset: only those written in the open sequence are read.
// A stall on the output holds the output register; the queue absorbs jobs
// until it fills, and only then does o_ready drop.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16be_transcoder #(
    parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [15:0] o_code_unit,
    output      logic        o_final_unit
);

    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    u8u16_pkg::t_job push_job;
    u8u16_pkg::t_job head_job;

    // Front end: sequence tracking; issues a job whenever a byte must
    // produce output (mark, finished sequence, single byte or flush).
    u8u16_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    // Decouples byte acceptance from unit emission.
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    // Decoder: scans each job's bytes, splits supplementary points into
    // surrogate pairs and marks the last unit of each job.
    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_unit  (o_code_unit),
        .o_final_unit (o_final_unit)
    );

    // A byte flagged first or last always produces output, so it must
    // issue a job in the cycle it is accepted.
    a_flag_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_first_byte || i_last_byte)) |-> q_push)
        else $error("flagged byte accepted without a job");

    // The decoder only takes jobs that the queue holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    // After reset the queue is empty and bytes are accepted.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("not ready or output valid after reset");

endmodule

`default_nettype wire

### sim/tb_utf8_to_utf16be_transcoder.sv
// Self-checking testbench for utf8_to_utf16be_transcoder: directed byte table,
// then random UTF-8 strings, checked against an in-bench model or typed units.
// Depends on u8u16_pkg and the transcoder RTL.
`timescale 1ns / 1ps

module tb_utf8_to_utf16be_transcoder;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_BYTES = 190;
    localparam int DIR_ROWS     = 26;

    // One expected code unit with its end-of-byte marker.
    typedef struct packed {
        logic [15:0] code;
        logic        fin;
    } t_unit;

    // Lead byte class: sequence length and payload bits (FFFD for a bad lead).
    typedef struct packed {
        logic [2:0]  len;
        logic [20:0] payload;
    } t_lead_cls;

    // Directed row. n_typed = 0 means the expectation comes from the model
    // below; otherwise unit0 (and unit1) are typed in by hand.
    typedef struct packed {
        logic [7:0]  in_b;
        logic        fst;
        logic        lst;
        logic [1:0]  n_typed;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_first_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_code_unit;
    logic        o_final_unit;

    // Transcoder model state
    int          pend_len;
    int          pend_count;
    logic [20:0] pend_point;
    logic [7:0]  pend_bytes [0:2];
    logic [7:0]  flush_buf [0:3];

    t_unit       step_units [$];
    t_unit       units_due [$];
    t_dir_row    dir_rows [0:DIR_ROWS-1];

    int cycle_count   = 0;
    int bytes_sent    = 0;
    int units_checked = 0;
    int mismatch_count = 0;

    utf8_to_utf16be_transcoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_unit  (o_code_unit),
        .o_final_unit (o_final_unit)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost unit ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Transcoder model
    // ------------------------------------------------------------------

    function automatic t_lead_cls classify_lead(input logic [7:0] c);
        t_lead_cls ld;
        if (!c[7]) begin
            ld.len     = 3'd1;
            ld.payload = {14'd0, c[6:0]};
        end else if (c[7:5] == 3'b110) begin
            ld.len     = 3'd2;
            ld.payload = {16'd0, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            ld.len     = 3'd3;
            ld.payload = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            ld.len     = 3'd4;
            ld.payload = {18'd0, c[2:0]};
        end else begin
            // stray continuation or 11111xxx: replacement character
            ld.len     = 3'd1;
            ld.payload = {5'd0, u8u16_pkg::UNIT_REPL};
        end
        return ld;
    endfunction

    task automatic push_unit(input logic [15:0] code);
        t_unit u;
        u.code = code;
        u.fin  = 1'b0;
        step_units.insert(step_units.size(), u);
    endtask

    // Points above the BMP become a surrogate pair; no range check, so even
    // 1FFFFF gives a (meaningless) pair.
    task automatic push_point(input logic [20:0] cp);
        logic [20:0] off;
        if (cp <= u8u16_pkg::BMP_MAX) begin
            push_unit(cp[15:0]);
        end else begin
            off = cp - u8u16_pkg::PLANE_BASE;
            push_unit(u8u16_pkg::UNIT_HI + {5'd0, off[20:10]});
            push_unit(u8u16_pkg::UNIT_LO + {6'd0, off[9:0]});
        end
    endtask

    // Decode flush_buf[0..n-1] as a string of its own; a lead that runs past
    // the end gives FFFD and the scan moves on by one byte.
    task automatic decode_flush(input int n);
        t_lead_cls   ld;
        logic [20:0] cp;
        int          i;
        int          j;
        int          len;
        i = 0;
        while (i < n) begin
            ld  = classify_lead(flush_buf[i]);
            cp  = ld.payload;
            len = ld.len;
            if (i + len > n) begin
                cp  = {5'd0, u8u16_pkg::UNIT_REPL};
                len = 1;
            end
            for (j = 1; j < len; j++) begin
                cp = {cp[14:0], flush_buf[i + j][5:0]};
            end
            i += len;
            push_point(cp);
        end
    endtask

    task automatic clear_sequence();
        pend_len   = 0;
        pend_count = 0;
        pend_point = '0;
    endtask

    // Units caused by one accepted byte land in step_units.
    task automatic transcode_byte(input logic [7:0] c, input logic fst, input logic lst);
        t_lead_cls   ld;
        t_unit       tail;
        int          n;
        int          i;
        step_units.delete();
        if (fst) begin
            clear_sequence();  // an open sequence is dropped silently
            push_unit(u8u16_pkg::UNIT_BOM);
        end
        if (lst) begin
            n = 0;
            if (pend_len != 0) begin
                for (i = 0; i < pend_count && i < 3; i++) begin
                    flush_buf[n] = pend_bytes[i];
                    n++;
                end
            end
            flush_buf[n] = c;
            n++;
            decode_flush(n);
            clear_sequence();
        end else if (pend_len == 0) begin
            ld = classify_lead(c);
            if (ld.len == 3'd1) begin
                push_point(ld.payload);
            end else begin
                pend_len      = ld.len;
                pend_count    = 1;
                pend_bytes[0] = c;
                pend_point    = ld.payload;
            end
        end else begin
            // continuation: only the low six bits count, the tag is not checked
            if (pend_count < 3) begin
                pend_bytes[pend_count] = c;
            end
            pend_point = {pend_point[14:0], c[5:0]};
            pend_count++;
            if (pend_count >= pend_len) begin
                push_point(pend_point);
                clear_sequence();
            end
        end
        if (step_units.size() > 0) begin
            tail     = step_units[step_units.size() - 1];
            tail.fin = 1'b1;
            step_units[step_units.size() - 1] = tail;
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Entered and left on a falling edge. Gaps are random except in a calm
    // window of the byte count.
    task automatic offer_byte(input logic [7:0] b, input logic fst, input logic lst,
                              input logic [1:0] n_typed, input logic [15:0] t0,
                              input logic [15:0] t1);
        t_unit       u;
        logic        calm;
        calm = (bytes_sent >= 150 && bytes_sent < 190);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_in_byte    <= b;
        i_first_byte <= fst;
        i_last_byte  <= lst;
        do @(posedge i_clk); while (!o_ready);
        // transaction accepted on this edge
        transcode_byte(b, fst, lst);
        if (n_typed == 2'd0) begin
            foreach (step_units[k]) units_due.insert(units_due.size(), step_units[k]);
        end else begin
            u = {t0, n_typed == 2'd1};
            units_due.insert(units_due.size(), u);
            if (n_typed == 2'd2) begin
                u = {t1, 1'b1};
                units_due.insert(units_due.size(), u);
            end
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        // mostly well-formed 10xxxxxx, now and then any byte at all
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // A random string: well-formed characters with random content, some noise,
    // and now and then a truncated tail or missing flags.
    task automatic offer_string();
        logic [7:0] str_q [$];
        int         nchars;
        int         ci;
        int         kind;
        int         cut;
        int         bi;
        logic       fst;
        logic       lst;
        nchars = $urandom_range(1, 6);
        for (ci = 0; ci < nchars; ci++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                str_q.insert(str_q.size(), {1'b0, 7'($urandom_range(0, 127))});
            end else if (kind <= 4) begin
                str_q.insert(str_q.size(), {3'b110, 5'($urandom_range(0, 31))});
                str_q.insert(str_q.size(), cont_byte());
            end else if (kind <= 6) begin
                str_q.insert(str_q.size(), {4'b1110, 4'($urandom_range(0, 15))});
                str_q.insert(str_q.size(), cont_byte());
                str_q.insert(str_q.size(), cont_byte());
            end else if (kind <= 8) begin
                str_q.insert(str_q.size(), {5'b11110, 3'($urandom_range(0, 7))});
                str_q.insert(str_q.size(), cont_byte());
                str_q.insert(str_q.size(), cont_byte());
                str_q.insert(str_q.size(), cont_byte());
            end else begin
                str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, 2);
            while (cut > 0 && str_q.size() > 1) begin
                void'(str_q.pop_back());
                cut--;
            end
        end
        for (bi = 0; bi < str_q.size(); bi++) begin
            fst = (bi == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            lst = (bi == str_q.size() - 1) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 19) == 0);
            offer_byte(str_q[bi], fst, lst, 2'd0, 16'h0, 16'h0);
        end
    endtask

    function automatic t_dir_row make_row(input logic [7:0] b, input logic fst,
                                          input logic lst, input logic [1:0] n,
                                          input logic [15:0] t0, input logic [15:0] t1);
        t_dir_row r;
        r = {b, fst, lst, n, t0, t1};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int str_idx;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_in_byte    = 8'h00;
        i_first_byte = 1'b0;
        i_last_byte  = 1'b0;
        clear_sequence();
        str_idx = 0;

        // a marked string start and the extremes of the one-byte class, typed in
        dir_rows[0]  = make_row(8'h41, 1'b1, 1'b0, 2'd2, u8u16_pkg::UNIT_BOM, 16'h0041);
        dir_rows[1]  = make_row(8'h00, 1'b0, 1'b0, 2'd1, 16'h0000, 16'h0);
        dir_rows[2]  = make_row(8'h7F, 1'b0, 1'b0, 2'd1, 16'h007F, 16'h0);
        // stray tail and invalid leads
        dir_rows[3]  = make_row(8'h80, 1'b0, 1'b0, 2'd1, u8u16_pkg::UNIT_REPL, 16'h0);
        dir_rows[4]  = make_row(8'hFF, 1'b0, 1'b0, 2'd1, u8u16_pkg::UNIT_REPL, 16'h0);
        dir_rows[5]  = make_row(8'hF8, 1'b0, 1'b0, 2'd1, u8u16_pkg::UNIT_REPL, 16'h0);
        // two-, three- and four-byte characters
        dir_rows[6]  = make_row(8'hC3, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[7]  = make_row(8'hA9, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[8]  = make_row(8'hE2, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[9]  = make_row(8'h82, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[10] = make_row(8'hAC, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[11] = make_row(8'hF0, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[12] = make_row(8'h9F, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[13] = make_row(8'h98, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[14] = make_row(8'h80, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        // largest point the lead can carry, no range check
        dir_rows[15] = make_row(8'hF7, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[16] = make_row(8'hBF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[17] = make_row(8'hBF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[18] = make_row(8'hBF, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        // multi-byte lead flagged as the last byte
        dir_rows[19] = make_row(8'hE2, 1'b0, 1'b1, 2'd1, u8u16_pkg::UNIT_REPL, 16'h0);
        // sequence cut short by the end of the string
        dir_rows[20] = make_row(8'hF0, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[21] = make_row(8'h9F, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[22] = make_row(8'h41, 1'b0, 1'b1, 2'd0, 16'h0, 16'h0);
        // new string starting mid-sequence drops the open one
        dir_rows[23] = make_row(8'hE2, 1'b0, 1'b0, 2'd0, 16'h0, 16'h0);
        dir_rows[24] = make_row(8'h41, 1'b1, 1'b0, 2'd2, u8u16_pkg::UNIT_BOM, 16'h0041);
        // one-byte string whose only byte is a lead
        dir_rows[25] = make_row(8'hC3, 1'b1, 1'b1, 2'd2, u8u16_pkg::UNIT_BOM,
                                u8u16_pkg::UNIT_REPL);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_byte(dir_rows[r].in_b, dir_rows[r].fst, dir_rows[r].lst,
                       dir_rows[r].n_typed, dir_rows[r].unit0, dir_rows[r].unit1);
        end

        while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
            offer_string();
            str_idx++;
            if (str_idx == 4) begin
                // sender pause: let the output side drain completely
                i_valid <= 1'b0;
                do @(negedge i_clk); while (units_due.size() != 0);
            end
        end
        i_valid <= 1'b0;

        while (units_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && units_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Unit receiver: random back-pressure, one long hold-off once enough
    // units have gone by (the queue fills and o_ready drops), and a calm
    // window with ready held high while the sender is calm too.
    // ------------------------------------------------------------------
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && units_checked >= 60) begin
                hold_done = 1'b1;
                hold_left = 80;
                i_ready <= 1'b0;
            end else if (bytes_sent >= 150 && bytes_sent < 190) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Checker: every accepted unit against the oldest expectation.
    always @(posedge i_clk) begin
        t_unit want;
        if (i_rst_n && o_valid && i_ready) begin
            if (units_due.size() == 0) begin
                $error("code_unit: no transaction expected, got %h (final_unit %b)",
                       o_code_unit, o_final_unit);
                mismatch_count++;
            end else begin
                want = units_due.pop_front();
                if (o_code_unit !== want.code) begin
                    $error("code_unit: expected %h, got %h", want.code, o_code_unit);
                    mismatch_count++;
                end
                if (o_final_unit !== want.fin) begin
                    $error("final_unit: expected %b, got %b", want.fin, o_final_unit);
                    mismatch_count++;
                end
            end
            units_checked++;
        end
    end

endmodule

### filelist.f
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_queue.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16be_transcoder.sv
sim/tb_utf8_to_utf16be_transcoder.sv
